/* src/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    ST_FILL,     // taking message bytes
    ST_COMP,     // loading the window and running the 64 rounds
    ST_PAD,      // writing pad bytes into the buffer
    ST_OUT       // delivering digest words
  } state_t;

  // byte source selects for the buffer write
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_en;      // write one byte into the buffer
    src_t       wr_src;
    logic [5:0] wr_addr;
    logic       cnt_inc;    // count a message byte
    logic       comp_start; // load window and working regs
    logic       comp_step;  // one round
    logic       comp_done;  // fold working regs into chaining value
    logic       msg_reset;  // back to IV, zero count
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic       load_done;  // window loaded from buffer
  } stat_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

/* src/sm3_datapath.sv */
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer, byte count, expansion window, working registers and
// chaining value; one compression round per step command.
// ----------------------------------------------------------------------------
module sm3_datapath import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  out_sel,
  input  logic [3:0]  load_idx,
  input  logic        load_en,
  input  logic [5:0]  round,
  output logic [31:0] out_word,
  output stat_t       stat
);

  logic [31:0] buffer [BLOCK_BYTES/4];
  logic [31:0] cv [8];
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [60:0] total_bytes;
  logic [63:0] bits;
  logic [7:0]  wr_byte;

  // length bytes, big-endian
  assign bits = {total_bytes, 3'b000};
  always_comb begin
    case (ctrl.wr_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bits[8*(7-ctrl.wr_addr[2:0]) +: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  // block buffer as big-endian words, one byte lane written per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      buffer[ctrl.wr_addr[5:2]][8*(3-ctrl.wr_addr[1:0]) +: 8] <= wr_byte;
    end
  end

  // byte count
  always_ff @(posedge clk) begin
    if (rst || ctrl.msg_reset) begin
      total_bytes <= '0;
    end else if (ctrl.cnt_inc) begin
      total_bytes <= total_bytes + 61'd1;
    end
  end

  // round logic
  logic [31:0] wj, wj4, wnew, tc, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        low;
  assign low = (round < 6'd16);
  assign wj  = w[round[3:0]];
  // W[j+4] from the window slots holding W[j-12], W[j-5], W[j+1], W[j-9], W[j-2]
  assign wnew = p1(w[round[3:0] + 4'd4] ^ w[round[3:0] + 4'd11]
                   ^ rol(w[round[3:0] + 4'd1], 5'd15))
              ^ rol(w[round[3:0] + 4'd7], 5'd7) ^ w[round[3:0] + 4'd14];
  assign wj4 = (round >= 6'd12) ? wnew : w[round[3:0] + 4'd4];
  assign tc  = low ? T_LOW : T_HIGH;
  assign a12 = rol(r[0], 5'd12);
  assign ss1 = rol(a12 + r[4] + rol(tc, round[4:0]), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = low ? (r[0] ^ r[1] ^ r[2]) :
               ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
  assign gg  = low ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
  assign tt1 = ff + r[3] + ss2 + (wj ^ wj4);
  assign tt2 = gg + r[7] + ss1 + wj;

  // expansion window: loaded word by word, then rolled during rounds
  always_ff @(posedge clk) begin
    if (load_en) begin
      w[load_idx] <= buffer[load_idx];
    end else if (ctrl.comp_step && round >= 6'd12) begin
      w[round[3:0] + 4'd4] <= wnew;
    end
  end
  assign stat.load_done = load_en && (load_idx == 4'd15);

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.comp_start) begin
      for (int i = 0; i < 8; i++) r[i] <= cv[i];
    end else if (ctrl.comp_step) begin
      r[3] <= r[2];
      r[2] <= rol(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rol(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= p0(tt2);
    end
  end

  // chaining value; the fold takes the outcome of the last round directly
  always_ff @(posedge clk) begin
    if (rst || ctrl.msg_reset) begin
      for (int i = 0; i < 8; i++) cv[i] <= IV[i];
    end else if (ctrl.comp_done) begin
      cv[0] <= cv[0] ^ tt1;
      cv[1] <= cv[1] ^ r[0];
      cv[2] <= cv[2] ^ rol(r[1], 5'd9);
      cv[3] <= cv[3] ^ r[2];
      cv[4] <= cv[4] ^ p0(tt2);
      cv[5] <= cv[5] ^ r[4];
      cv[6] <= cv[6] ^ rol(r[5], 5'd19);
      cv[7] <= cv[7] ^ r[6];
    end
  end

  assign out_word = cv[out_sel];

endmodule

/* src/sm3_ctrl.sv */
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: byte fill, padding, block load, rounds and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        in_valid_byte,
  input  logic        in_end,
  input  logic        out_fire,
  input  stat_t       stat,
  output logic        in_ready,
  output logic        out_valid,
  output logic [2:0]  out_sel,
  output logic [3:0]  load_idx,
  output logic        load_en,
  output logic [5:0]  round,
  output ctrl_t       ctrl
);

  state_t state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] round_next;
  logic [3:0] load_idx_next;
  logic       loading, loading_next;
  logic       pad_phase, pad_phase_next;  // message end seen, padding pending
  logic       pad_first, pad_first_next;  // 0x80 not yet written
  logic       len_block, len_block_next;  // current padded block holds length
  logic [2:0] out_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      fill <= '0;
      round <= '0;
      load_idx <= '0;
      loading <= 1'b0;
      pad_phase <= 1'b0;
      pad_first <= 1'b0;
      len_block <= 1'b0;
      out_sel <= '0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      round <= round_next;
      load_idx <= load_idx_next;
      loading <= loading_next;
      pad_phase <= pad_phase_next;
      pad_first <= pad_first_next;
      len_block <= len_block_next;
      out_sel <= out_sel_next;
    end
  end

  assign load_en = (state == ST_COMP) && loading;

  always_comb begin
    state_next = state;
    fill_next = fill;
    round_next = round;
    load_idx_next = load_idx;
    loading_next = loading;
    pad_phase_next = pad_phase;
    pad_first_next = pad_first;
    len_block_next = len_block;
    out_sel_next = out_sel;
    ctrl = '0;
    ctrl.wr_src = SRC_DATA;
    ctrl.wr_addr = fill;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_valid_byte) begin
            ctrl.wr_en = 1'b1;
            ctrl.cnt_inc = 1'b1;
            fill_next = fill + 6'd1;
          end
          if (in_end) begin
            pad_phase_next = 1'b1;
            pad_first_next = 1'b1;
          end
          if (in_valid_byte && fill == 6'd63) begin
            state_next = ST_COMP;
            loading_next = 1'b1;
            load_idx_next = '0;
          end else if (in_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.wr_en = 1'b1;
        if (pad_first) begin
          ctrl.wr_src = SRC_PAD;
          pad_first_next = 1'b0;
          len_block_next = (fill <= 6'd55);
        end else if (len_block && fill >= 6'd56) begin
          ctrl.wr_src = SRC_LEN;
        end else begin
          ctrl.wr_src = SRC_ZERO;
        end
        fill_next = fill + 6'd1;
        if (fill == 6'd63) begin
          state_next = ST_COMP;
          loading_next = 1'b1;
          load_idx_next = '0;
        end
      end
      ST_COMP: begin
        if (loading) begin
          load_idx_next = load_idx + 4'd1;
          if (stat.load_done) begin
            loading_next = 1'b0;
            ctrl.comp_start = 1'b1;
            round_next = '0;
          end
        end else begin
          ctrl.comp_step = 1'b1;
          round_next = round + 6'd1;
          if (round == 6'(ROUNDS - 1)) begin
            round_next = '0;
            ctrl.comp_done = 1'b1;
            if (!pad_phase) begin
              state_next = ST_FILL;
            end else if (len_block) begin
              state_next = ST_OUT;
              out_sel_next = '0;
            end else begin
              len_block_next = 1'b1;
              state_next = ST_PAD;
            end
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          out_sel_next = out_sel + 3'd1;
          if (out_sel == 3'd7) begin
            ctrl.msg_reset = 1'b1;
            pad_phase_next = 1'b0;
            len_block_next = 1'b0;
            state_next = ST_FILL;
          end
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // no input taken while a block or the digest is in flight
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP || state == ST_OUT) |-> !in_ready)
    else $error("input ready while busy");
  // full buffer always leads into compression
  a_full_comp: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_valid_byte && fill == 6'd63) |=> (state == ST_COMP && loading))
    else $error("full block not compressed");
  // digest word index advances by one per delivered word
  a_out_step: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_sel != 3'd7) |=> (out_sel == $past(out_sel) + 3'd1))
    else $error("digest index skipped");

endmodule

/* src/sm3_hash_engine_top.sv */
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// SM3 hash engine, byte-serial input, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one word per handshake: tdata = message byte,
//   tuser = byte valid flag, tlast = end of message. A last word with
//   tuser low ends the message without adding a byte (empty message ok).
//   Master stream gives eight words: tdata = digest word, tuser = index,
//   tlast on index 7.
//   Throughput: one byte per cycle while filling; a full block then holds
//   input while the window is loaded and the rounds run (one round per
//   cycle in the shared round unit).
//   End of message: pad bytes fill one or two pad blocks, each compressed
//   in turn, then the eight words.
//   Reset clears state to the standard IV and an empty buffer.
//   If the receiver stalls, the digest words hold and no input is taken
//   until all eight are delivered.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  ctrl_t      ctrl;
  stat_t      stat;
  logic [2:0] out_sel;
  logic [3:0] load_idx;
  logic       load_en;
  logic [5:0] round;

  sm3_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_tvalid && s_tready),
    .in_valid_byte(s_tuser),
    .in_end(s_tlast),
    .out_fire(m_tvalid && m_tready),
    .stat(stat),
    .in_ready(s_tready),
    .out_valid(m_tvalid),
    .out_sel(out_sel),
    .load_idx(load_idx),
    .load_en(load_en),
    .round(round),
    .ctrl(ctrl)
  );

  sm3_datapath u_dp (
    .clk(clk), .rst(rst),
    .ctrl(ctrl),
    .data_byte(s_tdata),
    .out_sel(out_sel),
    .load_idx(load_idx),
    .load_en(load_en),
    .round(round),
    .out_word(m_tdata),
    .stat(stat)
  );

  assign m_tuser = out_sel;
  assign m_tlast = (out_sel == 3'd7);

endmodule
